FILE: rtl/smfd_pkg.sv
// Package for the stack map frame decoder: parse phases, opcodes, result and error codes.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
package smfd_pkg;
   typedef enum logic [3:0] {
      PH_CNT_HI, PH_CNT_LO, PH_KIND, PH_DELTA_HI, PH_DELTA_LO, PH_LOC_TAG, PH_LOC_SKIP,
      PH_STK_TAG, PH_STK_SKIP, PH_NLOC_HI, PH_NLOC_LO, PH_NSTK_HI, PH_NSTK_LO,
      PH_DONE, PH_HALT
   } phase_type;

   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_PRELOAD = 3'd1;
   localparam logic [2:0] OP_TABLE   = 3'd2;
   localparam logic [2:0] OP_RD_LOC  = 3'd3;
   localparam logic [2:0] OP_RD_STK  = 3'd4;

   localparam logic [1:0] RK_FRAME = 2'd0;
   localparam logic [1:0] RK_READ  = 2'd1;
   localparam logic [1:0] RK_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_RESERVED = 3'd1;
   localparam logic [2:0] ERR_CHOP     = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_BAD_TAG  = 3'd4;

   localparam logic [7:0] TAG_MAX    = 8'd8;
   localparam logic [7:0] TAG_OBJECT = 8'd7;
   localparam logic [7:0] TAG_UNINIT = 8'd8;

   localparam logic [7:0] K_SAME_MAX  = 8'd63;
   localparam logic [7:0] K_ONE_MIN   = 8'd64;
   localparam logic [7:0] K_ONE_MAX   = 8'd127;
   localparam logic [7:0] K_ONE_EXT   = 8'd247;
   localparam logic [7:0] K_CHOP_MAX  = 8'd250;
   localparam logic [7:0] K_SAME_EXT  = 8'd251;
   localparam logic [7:0] K_APPEND_MX = 8'd254;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] start;
      logic [8:0]  lcount;
      logic [8:0]  scount;
      logic        last;
      logic [2:0]  err;
      logic        sel_stack;
      logic        in_range;
   } stage_type;
endpackage

FILE: rtl/stack_map_frame_decoder_top.sv
// StackMapTable frame decoder: one request per cycle while req_stall is low; results come from the output register.
// Throughput: one request every cycle unless req_stall is high; the tag stores take one write and one read a cycle.
// A result is registered in stage A, alongside the store read, and then in the output register.
// Reset: synchronous, clears parser registers and pipeline valids; tag stores are not cleared.
// Depends on smfd_pkg and smfd_ram.
`timescale 1ns / 1ps
module stack_map_frame_decoder_top
   import smfd_pkg::*;
#(
   parameter int MAX_LOCALS = 256,
   parameter int MAX_STACK  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_data,
   input  logic [7:0]  req_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_frame_start,
   output logic [8:0]  rsp_local_count,
   output logic [8:0]  rsp_stack_count,
   output logic [3:0]  rsp_type_tag,
   output logic        rsp_last_frame,
   output logic [2:0]  rsp_error_code
);
   localparam int LAW = $clog2(MAX_LOCALS);
   localparam int SAW = $clog2(MAX_STACK);
   localparam int LCW = $clog2(MAX_LOCALS + 1);
   localparam int SCW = $clog2(MAX_STACK + 1);

   // parser registers
   phase_type   phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] entries_ff, entries_in;
   logic [17:0] offset_ff, offset_in;
   logic [15:0] delta_ff, delta_in;
   logic [15:0] items_ff, items_in;
   logic [1:0]  skip_ff, skip_in;
   logic [LCW-1:0] lused_ff, lused_in;
   logic [SCW-1:0] sused_ff, sused_in;

   // pipeline: stage A waits on the store read, stage O holds the response
   logic      a_valid_ff;
   stage_type a_ff, a_in;
   logic      o_valid_ff;
   logic [3:0] tag_ff;
   stage_type o_ff;

   logic accept, a_move, a_load, emit;
   logic [1:0] e_kind;
   logic [2:0] e_err;
   logic       e_last;
   logic lwe, swe, lre, sre;
   logic [3:0] l_rd, s_rd;
   logic [17:0] off_step;
   logic [1:0] chop_n;

   // stage A may advance when the output register is empty or being taken
   assign a_move    = !o_valid_ff || !rsp_stall;
   // stage A may load when it is empty or advancing
   assign a_load    = !a_valid_ff || a_move;
   assign req_stall = a_valid_ff && !a_move;
   assign accept    = req_valid && !req_stall;

   smfd_ram #(.WIDTH(4), .DEPTH(MAX_LOCALS)) u_locals (
      .clock(clock), .wr_en(lwe), .wr_addr(lused_ff[LAW-1:0]), .wr_data(req_data[3:0]),
      .rd_en(lre), .rd_addr(LAW'(req_index)), .rd_data(l_rd)
   );
   smfd_ram #(.WIDTH(4), .DEPTH(MAX_STACK)) u_stack (
      .clock(clock), .wr_en(swe), .wr_addr(sused_ff[SAW-1:0]), .wr_data(req_data[3:0]),
      .rd_en(sre), .rd_addr(SAW'(req_index)), .rd_data(s_rd)
   );

   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      entries_in = entries_ff;
      offset_in  = offset_ff;
      delta_in   = delta_ff;
      items_in   = items_ff;
      skip_in    = skip_ff;
      lused_in   = lused_ff;
      sused_in   = sused_ff;
      emit = 1'b0;
      e_kind = RK_FRAME;
      e_err  = ERR_NONE;
      e_last = 1'b0;
      lwe = 1'b0;
      swe = 1'b0;
      lre = 1'b0;
      sre = 1'b0;
      off_step = 18'd0;
      chop_n = 2'(K_SAME_EXT - kind_ff);
      if (accept) begin
         unique case (req_opcode)
            OP_START: begin
               phase_in   = PH_CNT_HI;
               kind_in    = 8'd0;
               entries_in = 16'd0;
               offset_in  = 18'h3FFFF;
               delta_in   = 16'd0;
               items_in   = 16'd0;
               skip_in    = 2'd0;
               lused_in   = '0;
               sused_in   = '0;
            end
            OP_PRELOAD: begin
               if (req_data > TAG_MAX) begin
                  emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_BAD_TAG;
               end else if (17'(lused_ff) >= 17'(MAX_LOCALS)) begin
                  emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_OVERFLOW;
               end else begin
                  lwe = 1'b1;
                  lused_in = lused_ff + 1'b1;
               end
            end
            OP_RD_LOC: begin
               emit = 1'b1; e_kind = RK_READ; lre = 1'b1;
            end
            OP_RD_STK: begin
               emit = 1'b1; e_kind = RK_READ; sre = 1'b1;
            end
            OP_TABLE: begin
               unique case (phase_ff)
                  PH_CNT_HI: begin
                     entries_in = {req_data, 8'd0};
                     phase_in = PH_CNT_LO;
                  end
                  PH_CNT_LO: begin
                     entries_in = {entries_ff[15:8], req_data};
                     phase_in = (entries_in == 16'd0) ? PH_DONE : PH_KIND;
                  end
                  PH_KIND: begin
                     kind_in = req_data;
                     if (req_data <= K_SAME_MAX) begin
                        offset_in = offset_ff + 18'(req_data) + 18'd1;
                        sused_in = '0;
                        emit = 1'b1;
                     end else if (req_data <= K_ONE_MAX) begin
                        offset_in = offset_ff + 18'(req_data - K_ONE_MIN) + 18'd1;
                        sused_in = '0;
                        items_in = 16'd1;
                        phase_in = PH_STK_TAG;
                     end else if (req_data < K_ONE_EXT) begin
                        emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_RESERVED;
                        phase_in = PH_HALT;
                     end else begin
                        phase_in = PH_DELTA_HI;
                     end
                  end
                  PH_DELTA_HI: begin
                     delta_in = {req_data, 8'd0};
                     phase_in = PH_DELTA_LO;
                  end
                  PH_DELTA_LO: begin
                     delta_in = {delta_ff[15:8], req_data};
                     off_step = 18'(delta_in) + 18'd1;
                     offset_in = offset_ff + off_step;
                     sused_in = '0;
                     if (kind_ff == K_ONE_EXT) begin
                        items_in = 16'd1;
                        phase_in = PH_STK_TAG;
                     end else if (kind_ff <= K_CHOP_MAX) begin
                        emit = 1'b1;
                        if (17'(lused_ff) < 17'(chop_n)) begin
                           e_kind = RK_ERROR; e_err = ERR_CHOP;
                           phase_in = PH_HALT;
                        end else begin
                           lused_in = lused_ff - LCW'(chop_n);
                        end
                     end else if (kind_ff == K_SAME_EXT) begin
                        emit = 1'b1;
                     end else if (kind_ff <= K_APPEND_MX) begin
                        items_in = 16'(kind_ff - K_SAME_EXT);
                        phase_in = PH_LOC_TAG;
                     end else begin
                        lused_in = '0;
                        phase_in = PH_NLOC_HI;
                     end
                  end
                  PH_NLOC_HI: begin
                     items_in = {req_data, 8'd0};
                     phase_in = PH_NLOC_LO;
                  end
                  PH_NLOC_LO: begin
                     items_in = {items_ff[15:8], req_data};
                     if (items_in != 16'd0) phase_in = PH_LOC_TAG;
                     else phase_in = PH_NSTK_HI;
                  end
                  PH_NSTK_HI: begin
                     items_in = {req_data, 8'd0};
                     phase_in = PH_NSTK_LO;
                  end
                  PH_NSTK_LO: begin
                     items_in = {items_ff[15:8], req_data};
                     if (items_in != 16'd0) phase_in = PH_STK_TAG;
                     else emit = 1'b1;
                  end
                  PH_LOC_TAG: begin
                     if (req_data > TAG_MAX) begin
                        emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_BAD_TAG;
                        phase_in = PH_HALT;
                     end else if (17'(lused_ff) >= 17'(MAX_LOCALS)) begin
                        emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_OVERFLOW;
                        phase_in = PH_HALT;
                     end else begin
                        lwe = 1'b1;
                        lused_in = lused_ff + 1'b1;
                        items_in = items_ff - 16'd1;
                        if (req_data == TAG_OBJECT || req_data == TAG_UNINIT) begin
                           skip_in = 2'd2;
                           phase_in = PH_LOC_SKIP;
                        end else if (items_in != 16'd0) begin
                           phase_in = PH_LOC_TAG;
                        end else if (kind_ff == 8'hFF) begin
                           phase_in = PH_NSTK_HI;
                        end else begin
                           emit = 1'b1;
                        end
                     end
                  end
                  PH_LOC_SKIP: begin
                     skip_in = skip_ff - 2'd1;
                     if (skip_in == 2'd0) begin
                        if (items_ff != 16'd0) phase_in = PH_LOC_TAG;
                        else if (kind_ff == 8'hFF) phase_in = PH_NSTK_HI;
                        else emit = 1'b1;
                     end
                  end
                  PH_STK_TAG: begin
                     if (req_data > TAG_MAX) begin
                        emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_BAD_TAG;
                        phase_in = PH_HALT;
                     end else if (17'(sused_ff) >= 17'(MAX_STACK)) begin
                        emit = 1'b1; e_kind = RK_ERROR; e_err = ERR_OVERFLOW;
                        phase_in = PH_HALT;
                     end else begin
                        swe = 1'b1;
                        sused_in = sused_ff + 1'b1;
                        items_in = items_ff - 16'd1;
                        if (req_data == TAG_OBJECT || req_data == TAG_UNINIT) begin
                           skip_in = 2'd2;
                           phase_in = PH_STK_SKIP;
                        end else if (items_in != 16'd0) begin
                           phase_in = PH_STK_TAG;
                        end else begin
                           emit = 1'b1;
                        end
                     end
                  end
                  PH_STK_SKIP: begin
                     skip_in = skip_ff - 2'd1;
                     if (skip_in == 2'd0) begin
                        if (items_ff != 16'd0) phase_in = PH_STK_TAG;
                        else emit = 1'b1;
                     end
                  end
                  default: ;
               endcase
               // a completed frame retires one table entry
               if (emit && e_kind == RK_FRAME) begin
                  e_last = (entries_ff <= 16'd1);
                  entries_in = entries_ff - 16'd1;
                  phase_in = (entries_in == 16'd0) ? PH_DONE : PH_KIND;
               end
            end
            default: ;
         endcase
      end
      a_in.kind      = e_kind;
      a_in.start     = offset_in[15:0];
      a_in.lcount    = 9'(lused_in);
      a_in.scount    = 9'(sused_in);
      a_in.last      = e_last;
      a_in.err       = e_err;
      a_in.sel_stack = (req_opcode == OP_RD_STK);
      a_in.in_range  = (req_opcode == OP_RD_STK) ?
                       (17'(req_index) < 17'(sused_ff) && 17'(req_index) < 17'(MAX_STACK)) :
                       (17'(req_index) < 17'(lused_ff) && 17'(req_index) < 17'(MAX_LOCALS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CNT_HI;
         kind_ff    <= 8'd0;
         entries_ff <= 16'd0;
         offset_ff  <= 18'h3FFFF;
         delta_ff   <= 16'd0;
         items_ff   <= 16'd0;
         skip_ff    <= 2'd0;
         lused_ff   <= '0;
         sused_ff   <= '0;
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         entries_ff <= entries_in;
         offset_ff  <= offset_in;
         delta_ff   <= delta_in;
         items_ff   <= items_in;
         skip_ff    <= skip_in;
         lused_ff   <= lused_in;
         sused_ff   <= sused_in;
         // advance the output when it is free; fill stage A whenever it is empty or advancing
         if (a_move) o_valid_ff <= a_valid_ff;
         if (a_load) a_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         o_ff <= a_ff;
         if (a_ff.kind == RK_READ && a_ff.in_range) begin
            tag_ff <= a_ff.sel_stack ? s_rd : l_rd;
         end else begin
            tag_ff <= 4'd0;
         end
      end
      // hold stage A while stalled; the store read data holds with it
      if (accept) a_ff <= a_in;
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_result_kind = o_ff.kind;
   assign rsp_frame_start = o_ff.start;
   assign rsp_local_count = o_ff.lcount;
   assign rsp_stack_count = o_ff.scount;
   assign rsp_type_tag    = tag_ff;
   assign rsp_last_frame  = o_ff.last;
   assign rsp_error_code  = o_ff.err;

   // input stalls only when both pipeline slots are full behind a stalled output
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && o_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != RK_ERROR) |-> (rsp_error_code == ERR_NONE))
      else $error("error code on a non-error response");
   a_last_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != RK_FRAME) |-> !rsp_last_frame)
      else $error("last flag on a non-frame response");
   a_tag_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != RK_READ) |-> (rsp_type_tag == 4'd0))
      else $error("type tag on a non-read response");
endmodule

FILE: rtl/smfd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the local and stack tag stores.
`timescale 1ns / 1ps
module smfd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
